// ===== sv/wsfb_pkg.sv =====
`default_nettype none

package wsfb_pkg;

   localparam int unsigned OPCODE_W  = 4;
   localparam int unsigned LENGTH_W  = 16;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned KEY_W     = 32;
   localparam int unsigned LIMIT_W   = 17;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 32;
   localparam int unsigned HDR_POS_W = 3;

   localparam logic [BYTE_W-1:0]   FIN_BIT       = 8'h80;
   localparam logic [BYTE_W-1:0]   MASK_BIT      = 8'h80;
   localparam logic [BYTE_W-1:0]   EXT16_CODE    = 8'd126;
   localparam logic [LENGTH_W-1:0] SHORT_LEN_MAX = 16'd125;
   localparam logic [LIMIT_W-1:0]  HDR_SHORT     = 17'd6;
   localparam logic [LIMIT_W-1:0]  HDR_EXT       = 17'd8;

   localparam logic [KEY_W-1:0]    MASK_KEY_RESET  = 32'h1337_7742;
   localparam logic [LIMIT_W-1:0]  MAX_FRAME_RESET = 17'd2048;

   // header byte positions
   localparam logic [HDR_POS_W-1:0] POS_OPCODE   = 3'd0;
   localparam logic [HDR_POS_W-1:0] POS_LENGTH   = 3'd1;
   localparam logic [HDR_POS_W-1:0] POS_EXT_HI   = 3'd2;
   localparam logic [HDR_POS_W-1:0] POS_EXT_LO   = 3'd3;
   localparam logic [HDR_POS_W-1:0] POS_KEY_0    = 3'd4;
   localparam logic [HDR_POS_W-1:0] POS_KEY_LAST = 3'd7;

   typedef enum logic {
      CMD_BEGIN = 1'b0,
      CMD_DATA  = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MASK_KEY  = 1'b0,
      CSR_MAX_FRAME = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_byte;
      logic              reject;
   } rsp_word_type;

   function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_W-1:0] key,
                                                  input logic [1:0]       idx);
      logic [BYTE_W-1:0] b;
      case (idx)
         2'd0:    b = key[31:24];
         2'd1:    b = key[23:16];
         2'd2:    b = key[15:8];
         2'd3:    b = key[7:0];
         default: b = key[7:0];
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== sv/wsfb_if.sv =====
`default_nettype none

interface wsfb_req_if import wsfb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [OPCODE_W-1:0] opcode;
   logic [LENGTH_W-1:0] payload_length;
   logic                link_ready;
   logic [BYTE_W-1:0]   payload_byte;

   modport source (output valid, cmd, opcode, payload_length, link_ready, payload_byte,
                   input ready);
   modport sink   (input valid, cmd, opcode, payload_length, link_ready, payload_byte,
                   output ready);
endinterface

interface wsfb_rsp_if import wsfb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_byte;
   logic              reject;

   modport source (output valid, out_byte, last_byte, reject, input ready);
   modport sink   (input valid, out_byte, last_byte, reject, output ready);
endinterface

interface wsfb_csr_if import wsfb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/websocket_client_frame_builder_top.sv =====
`default_nettype none

// Channel   Dir  Word                                                     Accepted when
// req_ch    in   cmd, opcode, payload_length, link_ready, payload_byte   valid && ready
// rsp_ch    out  out_byte, last_byte, reject                              valid && ready
// csr_ch    in   index (0 mask_key, 1 max_frame_bytes), data              valid && ready
//
// A begin word emits its header one byte at a time, 6 bytes (8 with extended length), at
// one output byte per cycle while rsp_ch does not stall; req_ch is held off meanwhile.
// A refused begin emits one reject word. Results go through an output register backed by a
// skid register, so req_ch keeps moving while one result waits on rsp_ch.
// Synchronous reset clears frame state and loads the register defaults.

module websocket_client_frame_builder_top import wsfb_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   wsfb_req_if.sink   req_ch,
   wsfb_rsp_if.source rsp_ch,
   wsfb_csr_if.sink   csr_ch
);

   logic [KEY_W-1:0]     mask_key_ff, mask_key_in;
   logic [LIMIT_W-1:0]   max_frame_ff, max_frame_in;
   logic                 frame_open_ff, frame_open_in;
   logic                 discarding_ff, discarding_in;
   logic [LENGTH_W-1:0]  bytes_left_ff, bytes_left_in;
   logic [1:0]           mask_phase_ff, mask_phase_in;
   logic                 hdr_active_ff, hdr_active_in;
   logic [HDR_POS_W-1:0] hdr_pos_ff, hdr_pos_in;
   logic [OPCODE_W-1:0]  hdr_op_ff, hdr_op_in;
   logic [LENGTH_W-1:0]  hdr_len_ff, hdr_len_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;
   logic                 skid_valid_ff, skid_valid_in;
   rsp_word_type         skid_word_ff, skid_word_in;

   logic                 core_ready;
   logic                 req_fire;
   logic                 produce;
   rsp_word_type         prod_word;
   logic                 ext_len;
   logic [LIMIT_W-1:0]   total_bytes;
   logic                 refuse;
   logic [LENGTH_W-1:0]  left_dec;
   logic                 hdr_ext;

   function automatic logic [BYTE_W-1:0] hdr_byte(input logic [HDR_POS_W-1:0] pos,
                                                  input logic [OPCODE_W-1:0]  op,
                                                  input logic [LENGTH_W-1:0]  len,
                                                  input logic                 ext,
                                                  input logic [KEY_W-1:0]     key);
      logic [BYTE_W-1:0] b;
      case (pos)
         POS_OPCODE: b = FIN_BIT | {{(BYTE_W-OPCODE_W){1'b0}}, op};
         POS_LENGTH: b = ext ? (MASK_BIT | EXT16_CODE) : (MASK_BIT | len[BYTE_W-1:0]);
         POS_EXT_HI: b = len[15:8];
         POS_EXT_LO: b = len[7:0];
         default:    b = key_byte(key, pos[1:0]);
      endcase
      return b;
   endfunction

   assign core_ready   = !skid_valid_ff;
   assign req_ch.ready = core_ready && !hdr_active_ff;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign ext_len     = req_ch.payload_length > SHORT_LEN_MAX;
   assign total_bytes = {1'b0, req_ch.payload_length} + (ext_len ? HDR_EXT : HDR_SHORT);
   assign refuse      = !req_ch.link_ready || (total_bytes > max_frame_ff);
   assign left_dec    = bytes_left_ff - 1'b1;
   assign hdr_ext     = hdr_len_ff > SHORT_LEN_MAX;

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_byte  = rsp_word_ff.out_byte;
   assign rsp_ch.last_byte = rsp_word_ff.last_byte;
   assign rsp_ch.reject    = rsp_word_ff.reject;

   always_comb begin
      mask_key_in   = mask_key_ff;
      max_frame_in  = max_frame_ff;
      frame_open_in = frame_open_ff;
      discarding_in = discarding_ff;
      bytes_left_in = bytes_left_ff;
      mask_phase_in = mask_phase_ff;
      hdr_active_in = hdr_active_ff;
      hdr_pos_in    = hdr_pos_ff;
      hdr_op_in     = hdr_op_ff;
      hdr_len_in    = hdr_len_ff;
      produce       = 1'b0;
      prod_word     = '0;

      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_MASK_KEY:  mask_key_in  = csr_ch.data;
            CSR_MAX_FRAME: max_frame_in = csr_ch.data[LIMIT_W-1:0];
            default:       mask_key_in  = mask_key_ff;
         endcase
      end

      if (core_ready && hdr_active_ff) begin
         // stream the rest of the header, skipping the extended length when short
         produce             = 1'b1;
         prod_word.out_byte  = hdr_byte(hdr_pos_ff, hdr_op_ff, hdr_len_ff, hdr_ext,
                                        mask_key_ff);
         prod_word.last_byte = (hdr_pos_ff == POS_KEY_LAST) && (hdr_len_ff == '0);
         if (hdr_pos_ff == POS_KEY_LAST) begin
            hdr_active_in = 1'b0;
         end else if (hdr_pos_ff == POS_LENGTH && !hdr_ext) begin
            hdr_pos_in = POS_KEY_0;
         end else begin
            hdr_pos_in = hdr_pos_ff + 1'b1;
         end
      end else if (req_fire) begin
         if (cmd_type'(req_ch.cmd) == CMD_BEGIN) begin
            mask_phase_in = '0;
            bytes_left_in = req_ch.payload_length;
            discarding_in = refuse && (req_ch.payload_length != '0);
            frame_open_in = !refuse && (req_ch.payload_length != '0);
            produce       = 1'b1;
            if (refuse) begin
               prod_word.reject = 1'b1;
            end else begin
               prod_word.out_byte = hdr_byte(POS_OPCODE, req_ch.opcode,
                                             req_ch.payload_length, ext_len, mask_key_ff);
               hdr_active_in = 1'b1;
               hdr_pos_in    = POS_LENGTH;
               hdr_op_in     = req_ch.opcode;
               hdr_len_in    = req_ch.payload_length;
            end
         end else if (frame_open_ff) begin
            produce             = 1'b1;
            prod_word.out_byte  = req_ch.payload_byte ^ key_byte(mask_key_ff, mask_phase_ff);
            prod_word.last_byte = (left_dec == '0);
            bytes_left_in       = left_dec;
            mask_phase_in       = (left_dec == '0) ? 2'd0 : mask_phase_ff + 2'd1;
            frame_open_in       = (left_dec != '0);
         end else if (discarding_ff) begin
            // drop the byte of a refused frame
            bytes_left_in = left_dec;
            discarding_in = (left_dec != '0);
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (rsp_ch.ready) begin
            rsp_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (rsp_valid_ff && !rsp_ch.ready) begin
         // hold the waiting word, park the new one
         if (produce) begin
            skid_valid_in = 1'b1;
            skid_word_in  = prod_word;
         end
      end else begin
         rsp_valid_in = produce;
         if (produce) begin
            rsp_word_in = prod_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_key_ff   <= MASK_KEY_RESET;
         max_frame_ff  <= MAX_FRAME_RESET;
         frame_open_ff <= 1'b0;
         discarding_ff <= 1'b0;
         bytes_left_ff <= '0;
         mask_phase_ff <= '0;
         hdr_active_ff <= 1'b0;
         hdr_pos_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         mask_key_ff   <= mask_key_in;
         max_frame_ff  <= max_frame_in;
         frame_open_ff <= frame_open_in;
         discarding_ff <= discarding_in;
         bytes_left_ff <= bytes_left_in;
         mask_phase_ff <= mask_phase_in;
         hdr_active_ff <= hdr_active_in;
         hdr_pos_ff    <= hdr_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_op_ff    <= hdr_op_in;
      hdr_len_ff   <= hdr_len_in;
      rsp_word_ff  <= rsp_word_in;
      skid_word_ff <= skid_word_in;
   end

endmodule

`default_nettype wire
